// ----- hdl/ping_ack_rtt_collector_core_macros.svh -----
// Assertion macros shared by the ping/ack round-trip collector RTL.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef PING_ACK_RTT_COLLECTOR_CORE_MACROS_SVH
`define PING_ACK_RTT_COLLECTOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PACRC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PACRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/pacrc_pkg.sv -----
// Package for the ping/ack round-trip collector: codes, constants and types.
// Used by the engine and the top level; the channel interfaces share its field widths.
`default_nettype none

package pacrc_pkg;

    localparam int MAX_PEERS = 8;
    localparam int SLOT_W    = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Input item kinds.
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_PING = 2'd1;
    localparam logic [1:0] KIND_ACK  = 2'd2;
    localparam logic [1:0] KIND_SEND = 2'd3;

    // Result event codes.
    localparam logic [1:0] EV_TX_PING   = 2'd0;
    localparam logic [1:0] EV_TX_ACK    = 2'd1;
    localparam logic [1:0] EV_RTT       = 2'd2;
    localparam logic [1:0] EV_WIN_CLOSE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NODE_ID     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_NODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_WINDOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_DELAY  = 2'd3;

    localparam logic [7:0]  NODE_ID_RESET    = 8'd8;
    localparam logic [7:0]  TARGET_RESET     = 8'd0;
    localparam logic [23:0] ACK_WINDOW_RESET = 24'd24000;
    localparam logic [15:0] NODE_DELAY_RESET = 16'd2000;

    localparam logic [31:0] MID_SEED  = 32'hA5A5_0000;
    localparam logic [31:0] MID_STEP  = 32'h0001_0001;
    localparam logic [31:0] MID_RESET = MID_SEED ^ (32'(NODE_ID_RESET) << 16);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  source_node;
        logic [7:0]  dest_node;
        logic [15:0] seq_number;
        logic [31:0] message_id;
    } item_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  peer_node;
        logic [15:0] out_seq;
        logic [31:0] out_mid;
        logic [30:0] rtt_ms;
    } res_t;

    typedef struct packed {
        logic [7:0]  node_id;
        logic [7:0]  target_node;
        logic [23:0] window_len;
        logic [15:0] node_delay_ms;
    } cfg_t;

    // What the engine produces for the item it is looking at.
    typedef struct packed {
        logic [1:0] nres;
        res_t       res0;
        res_t       res1;
    } eng_out_t;

endpackage

`default_nettype wire

// ----- hdl/pacrc_item_if.sv -----
// Input channel of the ping/ack round-trip collector: one parsed event per item.
// Depends on pacrc_pkg for nothing but shares its field widths.
`default_nettype none

interface pacrc_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  source_node;
    logic [7:0]  dest_node;
    logic [15:0] seq_number;
    logic [31:0] message_id;

    modport source (
        output valid, kind, source_node, dest_node, seq_number, message_id,
        input  ready
    );
    modport sink (
        input  valid, kind, source_node, dest_node, seq_number, message_id,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/pacrc_result_if.sv -----
// Output channel of the ping/ack round-trip collector: zero, one or two results per item.
// Field widths follow the result record in pacrc_pkg.
`default_nettype none

interface pacrc_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [7:0]  peer_node;
    logic [15:0] out_seq;
    logic [31:0] out_mid;
    logic [30:0] rtt_ms;
    logic        last;

    modport source (
        output valid, event_res, peer_node, out_seq, out_mid, rtt_ms, last,
        input  ready
    );
    modport sink (
        input  valid, event_res, peer_node, out_seq, out_mid, rtt_ms, last,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/pacrc_cfg_if.sv -----
// Configuration write channel of the ping/ack round-trip collector.
// Carries a register index and write data; widths match pacrc_pkg.
`default_nettype none

interface pacrc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/ping_ack_rtt_collector_core.sv -----
// Top level of the ping/ack round-trip collector: channels, config registers,
// input register and result bundle. Depends on pacrc_pkg, the three channel
// interfaces, pacrc_engine and ping_ack_rtt_collector_core_macros.svh.
//
// Usage:
//   items   - sink channel of parsed events (tick, ping, ack, send request).
//   results - source channel of transmit/record/close results; last marks the
//             final result caused by one input item. Items that cause nothing
//             produce no result at all.
//   cfg     - register write channel, always ready; write only while idle.
// Path: an accepted item waits in the input register until it fires; its
//   results are then registered in the result bundle, which drives the
//   results channel.
// Throughput: one item per cycle while the receiver keeps ready high. A tick
//   that both closes the window and releases the delayed ack yields two
//   results; they leave one after another on the single result port, and
//   the next item with results waits until both are taken.
// Reset: all protocol state clears, the message-id counter is seeded from the
//   reset node id, and the registers return to their reset values.
// Stall: while the receiver holds ready low, the result bundle holds; the
//   input register still drains items that cause no result, and then the
//   input side stops accepting until the bundle is taken.
`default_nettype none

`include "ping_ack_rtt_collector_core_macros.svh"

module ping_ack_rtt_collector_core
    import pacrc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    pacrc_cfg_if.sink      cfg,
    pacrc_item_if.sink     items,
    pacrc_result_if.source results
);

    cfg_t     cfg_reg;
    logic     in_valid_reg;
    item_t    in_item_reg;
    eng_out_t eng;

    // Result bundle: up to two results from one item, sent one after another.
    res_t     bnd_reg [2];
    logic     out_valid_reg;
    logic     out_idx_reg;
    logic     out_two_reg;

    logic     in_load;
    logic     fire;
    logic     out_last;
    logic     last_pop;
    logic     out_free;
    logic     bnd_load;
    res_t     out_res;

    // Configuration writes land directly in the register file.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_id       <= NODE_ID_RESET;
            cfg_reg.target_node   <= TARGET_RESET;
            cfg_reg.window_len    <= ACK_WINDOW_RESET;
            cfg_reg.node_delay_ms <= NODE_DELAY_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_NODE_ID:     cfg_reg.node_id       <= cfg.data[7:0];
                REG_TARGET_NODE: cfg_reg.target_node   <= cfg.data[7:0];
                REG_ACK_WINDOW:  cfg_reg.window_len    <= cfg.data;
                REG_NODE_DELAY:  cfg_reg.node_delay_ms <= cfg.data[15:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // The item in the input register fires when its results have somewhere to
    // go: the bundle is empty, or is handing over its last result this cycle.
    assign out_last = !out_two_reg || out_idx_reg;
    assign last_pop = out_valid_reg && results.ready && out_last;
    assign out_free = !out_valid_reg || last_pop;
    assign fire     = in_valid_reg && (out_free || eng.nres == 2'd0);
    assign bnd_load = fire && eng.nres != 2'd0;

    assign items.ready = !in_valid_reg || fire;
    assign in_load     = items.valid && items.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_item_reg.kind        <= items.kind;
            in_item_reg.source_node <= items.source_node;
            in_item_reg.dest_node   <= items.dest_node;
            in_item_reg.seq_number  <= items.seq_number;
            in_item_reg.message_id  <= items.message_id;
        end
    end

    pacrc_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_item_reg),
        .cfg   (cfg_reg),
        .eng   (eng)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_idx_reg   <= 1'b0;
            out_two_reg   <= 1'b0;
        end
        else if (bnd_load)
        begin
            out_valid_reg <= 1'b1;
            out_idx_reg   <= 1'b0;
            out_two_reg   <= (eng.nres == 2'd2);
        end
        else if (last_pop)
        begin
            out_valid_reg <= 1'b0;
            out_idx_reg   <= 1'b0;
        end
        else if (out_valid_reg && results.ready)
        begin
            // First of two results taken; move on to the second.
            out_idx_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bnd_load)
        begin
            bnd_reg[0] <= eng.res0;
            bnd_reg[1] <= eng.res1;
        end
    end

    assign out_res = bnd_reg[out_idx_reg];

    assign results.valid     = out_valid_reg;
    assign results.event_res = out_res.event_res;
    assign results.peer_node = out_res.peer_node;
    assign results.out_seq   = out_res.out_seq;
    assign results.out_mid   = out_res.out_mid;
    assign results.rtt_ms    = out_res.rtt_ms;
    assign results.last      = out_last;

    // Results of a fired item never overwrite a bundle still being delivered.
    `PACRC_ASSERT_SAME(a_no_overwrite, bnd_load, out_free,
        "result bundle overwritten before delivery")
    // Only a tick can produce two results.
    `PACRC_ASSERT_SAME(a_two_only_tick, in_valid_reg && eng.nres == 2'd2,
        in_item_reg.kind == KIND_TICK, "two results from a non-tick item")
    // The second slot is only pointed at for a two-result bundle.
    `PACRC_ASSERT_SAME(a_idx_in_bundle, out_idx_reg, out_two_reg && out_valid_reg,
        "result index past the bundle")
    // Once the last result is taken and nothing new fired, the output is empty.
    `PACRC_ASSERT_NEXT(a_drain, last_pop && !bnd_load, !out_valid_reg,
        "output still valid after its last result")

endmodule

`default_nettype wire

// ----- hdl/pacrc_engine.sv -----
// Protocol state and per-item decision logic of the ping/ack collector.
// Depends on pacrc_pkg; state advances only when the top level fires an item.
`default_nettype none

module pacrc_engine
    import pacrc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     fire,
    input  wire item_t    item,
    input  wire cfg_t     cfg,
    output eng_out_t      eng
);

    logic [31:0]        time_now_reg,      time_now_next;
    logic               pend_valid_reg,    pend_valid_next;
    logic [31:0]        pend_due_reg,      pend_due_next;
    logic [7:0]         pend_dest_reg,     pend_dest_next;
    logic [15:0]        pend_seq_reg,      pend_seq_next;
    logic [31:0]        pend_mid_reg,      pend_mid_next;
    logic               win_open_reg,      win_open_next;
    logic [31:0]        win_start_reg,     win_start_next;
    logic [31:0]        win_end_reg,       win_end_next;
    logic [15:0]        sent_seq_reg,      sent_seq_next;
    logic [31:0]        sent_mid_reg,      sent_mid_next;
    logic [31:0]        mid_ctr_reg,       mid_ctr_next;
    logic [MAX_PEERS-1:0] seen_reg,        seen_next;

    logic [31:0]        time_inc;
    logic [31:0]        win_diff;
    logic [31:0]        due_diff;
    logic               win_close;
    logic               ack_due;
    logic [7:0]         self_id;
    logic [23:0]        self_delay;
    logic [23:0]        peer_delay;
    logic [31:0]        elapsed;
    logic signed [33:0] rtt_raw;
    logic [30:0]        rtt_val;
    logic               src_in_range;
    logic [SLOT_W-1:0]  slot;
    logic               rtt_hit;
    logic [15:0]        seq_inc;
    logic [31:0]        mid_inc;
    res_t               res_close;
    res_t               res_pend;

    // A moment is reached when the signed difference now - moment is not negative.
    assign time_inc  = time_now_reg + 32'd1;
    assign win_diff  = time_inc - win_end_reg;
    assign due_diff  = time_inc - pend_due_reg;
    assign win_close = win_open_reg && !win_diff[31];
    assign ack_due   = pend_valid_reg && !due_diff[31];

    assign self_id    = (cfg.node_id == 8'd0) ? 8'd1 : cfg.node_id;
    assign self_delay = 24'(self_id) * 24'(cfg.node_delay_ms);
    assign peer_delay = 24'(item.source_node) * 24'(cfg.node_delay_ms);

    // Round trip is the signed elapsed time less the peer's artificial delay.
    assign elapsed = time_now_reg - win_start_reg;
    assign rtt_raw = $signed({{2{elapsed[31]}}, elapsed}) - $signed({10'd0, peer_delay});
    assign rtt_val = (rtt_raw[33] || rtt_raw == 34'sd0) ? 31'd0 : rtt_raw[30:0];

    assign src_in_range = (item.source_node != 8'd0)
                       && (item.source_node <= 8'(MAX_PEERS));
    assign slot    = SLOT_W'(item.source_node - 8'd1);
    assign rtt_hit = win_open_reg && (item.message_id == sent_mid_reg)
                  && src_in_range && !seen_reg[slot];

    assign seq_inc = sent_seq_reg + 16'd1;
    assign mid_inc = mid_ctr_reg + MID_STEP;

    always_comb
    begin
        res_close           = '0;
        res_close.event_res = EV_WIN_CLOSE;
        res_close.out_seq   = sent_seq_reg;
        res_close.out_mid   = sent_mid_reg;

        res_pend            = '0;
        res_pend.event_res  = EV_TX_ACK;
        res_pend.peer_node  = pend_dest_reg;
        res_pend.out_seq    = pend_seq_reg;
        res_pend.out_mid    = pend_mid_reg;
    end

    always_comb
    begin
        time_now_next   = time_now_reg;
        pend_valid_next = pend_valid_reg;
        pend_due_next   = pend_due_reg;
        pend_dest_next  = pend_dest_reg;
        pend_seq_next   = pend_seq_reg;
        pend_mid_next   = pend_mid_reg;
        win_open_next   = win_open_reg;
        win_start_next  = win_start_reg;
        win_end_next    = win_end_reg;
        sent_seq_next   = sent_seq_reg;
        sent_mid_next   = sent_mid_reg;
        mid_ctr_next    = mid_ctr_reg;
        seen_next       = seen_reg;
        eng             = '0;

        unique case (item.kind)
            KIND_TICK:
            begin
                time_now_next = time_inc;
                if (win_close)
                begin
                    win_open_next = 1'b0;
                end
                if (ack_due)
                begin
                    pend_valid_next = 1'b0;
                end
                // The window closing always comes before the delayed ack.
                if (win_close)
                begin
                    eng.res0 = res_close;
                    eng.res1 = res_pend;
                end
                else
                begin
                    eng.res0 = res_pend;
                end
                eng.nres = 2'(win_close) + 2'(ack_due);
            end
            KIND_PING:
            begin
                if (item.dest_node == 8'd0)
                begin
                    // Broadcast: arm (or replace) the single delayed ack.
                    pend_valid_next = 1'b1;
                    pend_dest_next  = item.source_node;
                    pend_seq_next   = item.seq_number;
                    pend_mid_next   = item.message_id;
                    pend_due_next   = time_now_reg + 32'(self_delay);
                end
                else if (item.dest_node == cfg.node_id)
                begin
                    eng.nres           = 2'd1;
                    eng.res0.event_res = EV_TX_ACK;
                    eng.res0.peer_node = item.source_node;
                    eng.res0.out_seq   = item.seq_number;
                    eng.res0.out_mid   = item.message_id;
                end
            end
            KIND_ACK:
            begin
                if (rtt_hit)
                begin
                    seen_next[slot]    = 1'b1;
                    eng.nres           = 2'd1;
                    eng.res0.event_res = EV_RTT;
                    eng.res0.peer_node = item.source_node;
                    eng.res0.out_seq   = sent_seq_reg;
                    eng.res0.out_mid   = sent_mid_reg;
                    eng.res0.rtt_ms    = rtt_val;
                end
            end
            KIND_SEND:
            begin
                sent_seq_next      = seq_inc;
                mid_ctr_next       = mid_inc;
                sent_mid_next      = mid_inc;
                win_open_next      = 1'b1;
                win_start_next     = time_now_reg;
                win_end_next       = time_now_reg + 32'(cfg.window_len);
                seen_next          = '0;
                eng.nres           = 2'd1;
                eng.res0.event_res = EV_TX_PING;
                eng.res0.peer_node = cfg.target_node;
                eng.res0.out_seq   = seq_inc;
                eng.res0.out_mid   = mid_inc;
            end
            default:
            begin
                eng = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_now_reg   <= '0;
            pend_valid_reg <= 1'b0;
            pend_due_reg   <= '0;
            pend_dest_reg  <= '0;
            pend_seq_reg   <= '0;
            pend_mid_reg   <= '0;
            win_open_reg   <= 1'b0;
            win_start_reg  <= '0;
            win_end_reg    <= '0;
            sent_seq_reg   <= '0;
            sent_mid_reg   <= '0;
            mid_ctr_reg    <= MID_RESET;
            seen_reg       <= '0;
        end
        else if (fire)
        begin
            time_now_reg   <= time_now_next;
            pend_valid_reg <= pend_valid_next;
            pend_due_reg   <= pend_due_next;
            pend_dest_reg  <= pend_dest_next;
            pend_seq_reg   <= pend_seq_next;
            pend_mid_reg   <= pend_mid_next;
            win_open_reg   <= win_open_next;
            win_start_reg  <= win_start_next;
            win_end_reg    <= win_end_next;
            sent_seq_reg   <= sent_seq_next;
            sent_mid_reg   <= sent_mid_next;
            mid_ctr_reg    <= mid_ctr_next;
            seen_reg       <= seen_next;
        end
    end

endmodule

`default_nettype wire
